FILE: design/cjsr_pkg.sv
// Shared types and constants for the cosine joint setpoint ramp.
// No dependencies; used by the top level and the cosine table.
package cjsr_pkg;

  localparam int POS_W   = 16;  // Q3.12 joint angle
  localparam int COS_W   = 16;  // Q1.15 cosine
  localparam int PHASE_W = 17;  // Q1.16 phase, 0 .. 1.0
  localparam int STEP_W  = 17;
  localparam int ACT_W   = 6;
  localparam int IDX_W   = 5;   // joint_index field
  localparam int MAX_OUT = 32;

  localparam logic [PHASE_W-1:0] PHASE_ONE = 17'h10000;
  localparam logic [STEP_W-1:0]  STEP_RESET = 17'd655;
  localparam logic [ACT_W-1:0]   ACT_RESET  = 6'd32;

  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint Q30_ONE = 64'sd1073741824;

  // operation codes
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_CAPTURE = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // configuration register indexes
  localparam logic CFG_PHASE_STEP    = 1'b0;
  localparam logic CFG_ACTIVE_JOINTS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_WEIGHT,
    ST_RUN
  } state_t;

endpackage

FILE: design/cjsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cjsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/cjsr_cos_rom.sv
// Cosine table cos(pi*k/COS_STEPS) in Q1.15, built at elaboration, registered read.
// Depends on cjsr_pkg.
module cjsr_cos_rom #(
  parameter int COS_STEPS = 1024
) (
  input  logic                                 clk,
  input  logic                                 re,
  input  logic [$clog2(COS_STEPS+1)-1:0]       addr,
  output logic signed [cjsr_pkg::COS_W-1:0]    data
);

  localparam int IW = $clog2(COS_STEPS + 1);

  // Taylor series in Q30, mirrored about a quarter turn for accuracy
  function automatic logic signed [cjsr_pkg::COS_W-1:0] cos_entry(input int k);
    longint kk;
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint c;
    bit     neg;
    kk  = longint'(k);
    neg = 1'b0;
    if (COS_STEPS - k < k) begin
      kk  = longint'(COS_STEPS - k);
      neg = 1'b1;
    end
    x    = (cjsr_pkg::PI_Q30 * kk) / COS_STEPS;
    x2   = (x * x) >>> 30;
    term = cjsr_pkg::Q30_ONE;
    sum  = cjsr_pkg::Q30_ONE;
    for (int n = 1; n <= 10; n++) begin
      term = (term * x2) >>> 30;
      case (n)
        1:       term = term / 2;
        2:       term = term / 12;
        3:       term = term / 30;
        4:       term = term / 56;
        5:       term = term / 90;
        6:       term = term / 132;
        7:       term = term / 182;
        8:       term = term / 240;
        9:       term = term / 306;
        default: term = term / 380;
      endcase
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    c = (sum + 16384) >>> 15;
    if (neg) begin
      c = -c;
      if (c < -32768) begin
        c = -32768;
      end
    end else if (c > 32767) begin
      c = 32767;
    end
    return cjsr_pkg::COS_W'(c);
  endfunction

  logic signed [cjsr_pkg::COS_W-1:0] rom [2**IW];

  for (genvar k = 0; k < 2**IW; k++) begin : g_entry
    if (k <= COS_STEPS) begin : g_used
      localparam logic signed [cjsr_pkg::COS_W-1:0] ENTRY = cos_entry(k);
      assign rom[k] = ENTRY;
    end else begin : g_pad
      assign rom[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      data <= rom[addr];
    end
  end

endmodule

FILE: design/cosine_joint_setpoint_ramp.sv
// Cosine setpoint ramp: top level with control, phase, weight and blend pipeline.
// Depends on cjsr_pkg, cjsr_ram and cjsr_cos_rom.
//
// Usage
//   Input channel (item_valid / item_stall): operation, joint, position.
//   A load stores a target angle, a capture stores a start angle and clears
//   the phase; both are taken in the idle state. A tick advances the phase
//   (saturating at 1.0), looks up the cosine weight, then streams one
//   setpoint per active joint, joint 0 first, with last set on the final one.
//   Output channel (result_valid / result_stall): joint_index, setpoint, last.
//   A tick goes through the phase register and the cosine table read, then
//   one read a cycle of the start/target RAMs while the output is not stalled.
//   A stalled output freezes the whole blend pipeline, RAM read included;
//   nothing is dropped. Input accepts again once the last joint is issued.
//   Reset: phase zero, phase_step 655, active_joints 32, all joint angles
//   read as zero (per-entry valid bits, no clearing pass needed). The block does
//   not gate configuration writes (cfg_write): the user sends them only in idle.
module cosine_joint_setpoint_ramp #(
  parameter int NUM_JOINTS = 32,
  parameter int COS_STEPS  = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [cjsr_pkg::STEP_W-1:0]       cfg_data,
  // items in
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [1:0]                        operation,
  input  logic [4:0]                        joint,
  input  logic signed [cjsr_pkg::POS_W-1:0] position,
  // results out
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [cjsr_pkg::IDX_W-1:0]        joint_index,
  output logic signed [cjsr_pkg::POS_W-1:0] setpoint,
  output logic                              last
);

  localparam int JW   = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int IW   = $clog2(COS_STEPS + 1);
  localparam int PW   = cjsr_pkg::PHASE_W + IW;
  localparam int MAXC = (NUM_JOINTS < cjsr_pkg::MAX_OUT) ? NUM_JOINTS : cjsr_pkg::MAX_OUT;
  localparam int PRW  = 35;  // 17-bit diff x 18-bit weight

  // ---------------- configuration registers ----------------
  logic [cjsr_pkg::STEP_W-1:0] phase_step;
  logic [cjsr_pkg::ACT_W-1:0]  active_joints;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= cjsr_pkg::STEP_RESET;
      active_joints <= cjsr_pkg::ACT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cjsr_pkg::CFG_PHASE_STEP:    phase_step    <= cfg_data;
        cjsr_pkg::CFG_ACTIVE_JOINTS: active_joints <= cfg_data[cjsr_pkg::ACT_W-1:0];
      endcase
    end
  end

  // ---------------- control ----------------
  cjsr_pkg::state_t state;
  cjsr_pkg::state_t state_next;

  logic                        take;       // input transfer
  logic                        adv;        // blend pipeline moves
  logic                        issue;      // one joint read issued
  logic                        rom_re;
  logic                        load_w;
  logic                        v1;
  logic                        v2;
  logic [cjsr_pkg::ACT_W-1:0]  cnt;
  logic [cjsr_pkg::ACT_W-1:0]  cnt_next;
  logic [cjsr_pkg::ACT_W-1:0]  j;
  logic                        j_last;
  logic                        joint_ok;

  assign take     = item_valid && !item_stall;
  assign adv      = !result_valid || !result_stall;
  assign j_last   = (j + 1'b1) == cnt;
  assign joint_ok = 32'(joint) < NUM_JOINTS;
  assign cnt_next = (32'(active_joints) > MAXC) ? cjsr_pkg::ACT_W'(MAXC) : active_joints;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cjsr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_stall = 1'b1;
    rom_re     = 1'b0;
    load_w     = 1'b0;
    issue      = 1'b0;
    unique case (state)
      cjsr_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid && operation == cjsr_pkg::OP_TICK && cnt_next != '0) begin
          state_next = cjsr_pkg::ST_LOOKUP;
        end
      end
      cjsr_pkg::ST_LOOKUP: begin
        rom_re     = 1'b1;
        state_next = cjsr_pkg::ST_WEIGHT;
      end
      cjsr_pkg::ST_WEIGHT: begin
        // previous tick's joints must be past the multiplier before w changes
        if (!v1 && !v2) begin
          load_w     = 1'b1;
          state_next = cjsr_pkg::ST_RUN;
        end
      end
      cjsr_pkg::ST_RUN: begin
        issue = adv;
        if (adv && j_last) begin
          state_next = cjsr_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // ---------------- phase, count, joint counter ----------------
  logic [cjsr_pkg::PHASE_W-1:0] phase;
  logic [cjsr_pkg::PHASE_W:0]   phase_sum;

  assign phase_sum = {1'b0, phase} + {1'b0, phase_step};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      cnt   <= '0;
      j     <= '0;
    end else begin
      if (take && operation == cjsr_pkg::OP_CAPTURE) begin
        phase <= '0;
      end else if (take && operation == cjsr_pkg::OP_TICK) begin
        phase <= (phase_sum > {1'b0, cjsr_pkg::PHASE_ONE}) ? cjsr_pkg::PHASE_ONE
                                                           : phase_sum[cjsr_pkg::PHASE_W-1:0];
        cnt   <= cnt_next;
      end
      if (load_w) begin
        j <= '0;
      end else if (issue) begin
        j <= j + 1'b1;
      end
    end
  end

  // ---------------- cosine lookup and weight ----------------
  logic [PW-1:0]                      idx_prod;
  logic [IW-1:0]                      cos_addr;
  logic signed [cjsr_pkg::COS_W-1:0]  cos_rd;
  logic [cjsr_pkg::PHASE_W-1:0]       w;   // (1-cos)/2 in Q1.16, 1 .. 65536

  assign idx_prod = PW'(phase) * PW'(COS_STEPS);
  assign cos_addr = idx_prod[16 +: IW];

  cjsr_cos_rom #(
    .COS_STEPS(COS_STEPS)
  ) u_cos (
    .clk (clk),
    .re  (rom_re),
    .addr(cos_addr),
    .data(cos_rd)
  );

  always_ff @(posedge clk) begin
    if (load_w) begin
      w <= cjsr_pkg::PHASE_W'(18'sd32768 - 18'(cos_rd));
    end
  end

  // ---------------- joint angle stores ----------------
  logic                           wr_target;
  logic                           wr_start;
  logic [JW-1:0]                  waddr;
  logic [JW-1:0]                  raddr;
  logic [NUM_JOINTS-1:0]          start_vld;
  logic [NUM_JOINTS-1:0]          target_vld;
  logic [cjsr_pkg::POS_W-1:0]     start_rd;
  logic [cjsr_pkg::POS_W-1:0]     target_rd;

  assign wr_target = take && operation == cjsr_pkg::OP_LOAD && joint_ok;
  assign wr_start  = take && operation == cjsr_pkg::OP_CAPTURE && joint_ok;
  assign waddr     = JW'(joint);
  assign raddr     = JW'(j);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_vld  <= '0;
      target_vld <= '0;
    end else begin
      if (wr_start) begin
        start_vld[waddr] <= 1'b1;
      end
      if (wr_target) begin
        target_vld[waddr] <= 1'b1;
      end
    end
  end

  cjsr_ram #(
    .WIDTH(cjsr_pkg::POS_W),
    .DEPTH(NUM_JOINTS)
  ) u_start (
    .clk  (clk),
    .we   (wr_start),
    .waddr(waddr),
    .wdata(position),
    .re   (adv),
    .raddr(raddr),
    .rdata(start_rd)
  );

  cjsr_ram #(
    .WIDTH(cjsr_pkg::POS_W),
    .DEPTH(NUM_JOINTS)
  ) u_target (
    .clk  (clk),
    .we   (wr_target),
    .waddr(waddr),
    .wdata(position),
    .re   (adv),
    .raddr(raddr),
    .rdata(target_rd)
  );

  // ---------------- blend pipeline ----------------
  // S1: RAM data out; S2: product; S3: round, add start, saturate.
  logic [cjsr_pkg::IDX_W-1:0]        j1;
  logic                              last1;
  logic                              sv1;
  logic                              tv1;
  logic signed [cjsr_pkg::POS_W-1:0] s1;
  logic signed [cjsr_pkg::POS_W-1:0] t1;
  logic signed [cjsr_pkg::POS_W:0]   d1;

  logic [cjsr_pkg::IDX_W-1:0]        j2;
  logic                              last2;
  logic signed [cjsr_pkg::POS_W-1:0] s2;
  logic signed [PRW-1:0]             prod;

  logic signed [PRW:0]               rounded;
  logic signed [19:0]                sum3;

  assign s1 = sv1 ? signed'(start_rd) : '0;
  assign t1 = tv1 ? signed'(target_rd) : '0;
  assign d1 = 17'(t1) - 17'(s1);

  assign rounded = (PRW+1)'(prod) + (PRW+1)'(36'sd32768);
  assign sum3    = 20'(s2) + rounded[PRW:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      v1           <= issue;
      v2           <= v1;
      result_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j1    <= j[cjsr_pkg::IDX_W-1:0];
      last1 <= j_last;
      sv1   <= start_vld[raddr];
      tv1   <= target_vld[raddr];

      j2    <= j1;
      last2 <= last1;
      s2    <= s1;
      prod  <= PRW'(d1 * signed'({1'b0, w}));

      joint_index <= j2;
      last        <= last2;
      if (sum3 > 20'sd32767) begin
        setpoint <= 16'sd32767;
      end else if (sum3 < -20'sd32768) begin
        setpoint <= -16'sd32768;
      end else begin
        setpoint <= sum3[cjsr_pkg::POS_W-1:0];
      end
    end
  end

  // ---------------- assertions ----------------
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= cjsr_pkg::PHASE_ONE)
    else $error("phase above 1.0");

  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    state == cjsr_pkg::ST_RUN |-> (j < cnt))
    else $error("joint counter past active count");

  a_weight_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == cjsr_pkg::ST_RUN |-> w != '0)
    else $error("zero blend weight while streaming");

  a_weight_safe: assert property (@(posedge clk) disable iff (rst)
    load_w |-> !v1 && !v2)
    else $error("weight changed with joints in flight");

endmodule
